/* sv/kpsh_pkg.sv */
// Shared types, codes and the key character table for the keypad scanner.
package kpsh_pkg;

	localparam int ROWS = 4;
	localparam int COLS = 5;
	localparam int ROW_W = 2;
	localparam int COL_W = 3;
	localparam int CNT_W = 16;
	localparam int CODE_W = 8;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 8'd1;

	localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
	localparam logic [CNT_W-1:0] HOLD_RST = 16'd1000;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	localparam logic [COLS-1:0] ALL_COLS = 5'b11111;
	localparam logic [COLS-1:0] FIRST_COL = 5'b00001;

	localparam logic [KIND_W-1:0] EV_PRESS = 2'd0;
	localparam logic [KIND_W-1:0] EV_HOLD = 2'd1;
	localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

	typedef enum logic [3:0] {
		PH_ANY = 4'b0001,
		PH_WAIT = 4'b0010,
		PH_COL = 4'b0100,
		PH_LAST = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		MODE_REL = 3'b001,
		MODE_TIME = 3'b010,
		MODE_HELD = 3'b100
	} mode_t;

	typedef struct packed {
		logic [COLS-1:0] col_drive;
		logic event_valid;
		logic [CODE_W-1:0] key_code;
		logic [KIND_W-1:0] event_kind;
	} res_t;

	localparam logic [CODE_W-1:0] KEY_TABLE [ROWS][COLS] = '{
		'{"1", "2", "3", "X", "Y"},
		'{"4", "5", "6", "7", "Z"},
		'{"8", "9", "A", "B", "C"},
		'{"W", "T", "D", "E", "F"}
	};

	function automatic logic [CODE_W-1:0] key_lookup(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		logic [CODE_W-1:0] code;
		code = '0;
		if (col < COL_W'(COLS)) begin
			code = KEY_TABLE[row][col];
		end
		return code;
	endfunction

endpackage

/* sv/kpsh_core.sv */
// Scan sequencer and press/hold/release tracker: one tick per step.
module kpsh_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [kpsh_pkg::ROWS-1:0]     rows,
	input  logic [kpsh_pkg::CNT_W-1:0]    debounce_ticks,
	input  logic [kpsh_pkg::CNT_W-1:0]    hold_ticks,
	output kpsh_pkg::res_t                res
);

	kpsh_pkg::phase_t phase_q, phase_d;
	kpsh_pkg::mode_t mode_q, mode_d;
	logic [kpsh_pkg::COL_W-1:0] col_q, col_d;
	logic [kpsh_pkg::CNT_W-1:0] deb_cnt_q, deb_cnt_d;
	logic [kpsh_pkg::CNT_W-1:0] elapsed_q, elapsed_d;
	logic [kpsh_pkg::CODE_W-1:0] held_q, held_d;

	logic any_row;
	logic [kpsh_pkg::ROW_W-1:0] low_row;
	logic [kpsh_pkg::CNT_W-1:0] deb_inc, elapsed_inc;
	logic [kpsh_pkg::COL_W-1:0] col_next;
	logic done, found;
	logic [kpsh_pkg::CODE_W-1:0] code;
	logic [kpsh_pkg::COLS-1:0] drive;
	logic ev_valid;
	logic [kpsh_pkg::CODE_W-1:0] ev_code;
	logic [kpsh_pkg::KIND_W-1:0] ev_kind;

	assign any_row = |rows;
	assign deb_inc = (deb_cnt_q == kpsh_pkg::CNT_MAX) ? deb_cnt_q : deb_cnt_q + 16'd1;
	assign elapsed_inc = (elapsed_q == kpsh_pkg::CNT_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign col_next = col_q + 3'd1;

	// priority to the lowest row
	always_comb begin
		low_row = '0;
		for (int i = kpsh_pkg::ROWS - 1; i >= 0; i--) begin
			if (rows[i]) begin
				low_row = kpsh_pkg::ROW_W'(i);
			end
		end
	end

	// scan sequencer
	always_comb begin
		phase_d = phase_q;
		col_d = col_q;
		deb_cnt_d = deb_cnt_q;
		drive = kpsh_pkg::ALL_COLS;
		done = 1'b0;
		found = 1'b0;
		code = '0;
		case (phase_q)
			kpsh_pkg::PH_WAIT: begin
				deb_cnt_d = deb_inc;
				if (deb_inc >= debounce_ticks) begin
					if (any_row) begin
						col_d = '0;
						drive = kpsh_pkg::FIRST_COL;
						phase_d = kpsh_pkg::PH_COL;
					end else begin
						done = 1'b1;
						phase_d = kpsh_pkg::PH_ANY;
					end
				end
			end
			kpsh_pkg::PH_COL: begin
				if (any_row) begin
					done = 1'b1;
					found = 1'b1;
					code = kpsh_pkg::key_lookup(low_row, col_q);
					phase_d = kpsh_pkg::PH_ANY;
				end else begin
					col_d = col_next;
					if (col_next < kpsh_pkg::COL_W'(kpsh_pkg::COLS - 1)) begin
						drive = kpsh_pkg::FIRST_COL << col_next;
					end else begin
						phase_d = kpsh_pkg::PH_LAST;
					end
				end
			end
			kpsh_pkg::PH_LAST: begin
				done = 1'b1;
				found = any_row;
				if (any_row) begin
					code = kpsh_pkg::key_lookup(low_row,
						kpsh_pkg::COL_W'(kpsh_pkg::COLS - 1));
				end
				phase_d = kpsh_pkg::PH_ANY;
			end
			default: begin
				if (any_row) begin
					deb_cnt_d = '0;
					phase_d = kpsh_pkg::PH_WAIT;
				end else begin
					done = 1'b1;
					phase_d = kpsh_pkg::PH_ANY;
				end
			end
		endcase
	end

	// key event tracking; hold timeout wins over a scan ending the same tick
	always_comb begin
		mode_d = mode_q;
		elapsed_d = elapsed_q;
		held_d = held_q;
		ev_valid = 1'b0;
		ev_code = '0;
		ev_kind = kpsh_pkg::EV_PRESS;
		case (mode_q)
			kpsh_pkg::MODE_TIME: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= hold_ticks) begin
					ev_valid = 1'b1;
					ev_kind = kpsh_pkg::EV_HOLD;
					ev_code = held_q;
					mode_d = kpsh_pkg::MODE_HELD;
				end else if (done && !found) begin
					ev_valid = 1'b1;
					ev_kind = kpsh_pkg::EV_PRESS;
					ev_code = held_q;
					mode_d = kpsh_pkg::MODE_REL;
				end
			end
			kpsh_pkg::MODE_HELD: begin
				if (done) begin
					ev_valid = 1'b1;
					if (found) begin
						ev_kind = kpsh_pkg::EV_HOLD;
						ev_code = code;
						held_d = code;
					end else begin
						ev_kind = kpsh_pkg::EV_RELEASE;
						ev_code = held_q;
						mode_d = kpsh_pkg::MODE_REL;
					end
				end
			end
			default: begin
				mode_d = kpsh_pkg::MODE_REL;
				if (done && found) begin
					held_d = code;
					elapsed_d = '0;
					mode_d = kpsh_pkg::MODE_TIME;
				end
			end
		endcase
	end

	assign res = {drive, ev_valid, ev_code, ev_kind};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kpsh_pkg::PH_ANY;
			mode_q <= kpsh_pkg::MODE_REL;
			col_q <= '0;
			deb_cnt_q <= '0;
			elapsed_q <= '0;
			held_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			mode_q <= mode_d;
			col_q <= col_d;
			deb_cnt_q <= deb_cnt_d;
			elapsed_q <= elapsed_d;
			held_q <= held_d;
		end
	end

endmodule

/* sv/matrix_keypad_scan_hold_unit.sv */
// Keypad scanner top level: config registers, input and result registers around the core.
// Each row sample (beat) gives exactly one result beat: the column pattern to drive next
// plus an optional press, hold or release event. A beat passes an input register, then a
// result register; throughput is one beat per clock while the result side does not stall,
// since the whole scan sequencer and both tick counters update together on each step.
// The input side stalls only when both registers hold beats and the result side is
// stalled. Registers: index 0 is the debounce wait in ticks, index 1 the hold timeout in
// ticks; write them only while no beat is in flight.
module matrix_keypad_scan_hold_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [kpsh_pkg::ROWS-1:0]         row_levels,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [kpsh_pkg::COLS-1:0]         col_drive,
	output logic                              event_valid,
	output logic [kpsh_pkg::CODE_W-1:0]       key_code,
	output logic [kpsh_pkg::KIND_W-1:0]       event_kind,
	input  logic                              cfg_we,
	input  logic [kpsh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kpsh_pkg::CNT_W-1:0]        cfg_data
);

	logic [kpsh_pkg::CNT_W-1:0] debounce_q, hold_q;
	logic valid_s1, valid_s2;
	logic [kpsh_pkg::ROWS-1:0] rows_s1;
	kpsh_pkg::res_t res, res_s2;
	logic advance, step;

	assign advance = !valid_s2 || !out_stall;
	assign step = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kpsh_pkg::DEBOUNCE_RST;
			hold_q <= kpsh_pkg::HOLD_RST;
		end else if (cfg_we) begin
			if (cfg_index == kpsh_pkg::CFG_DEBOUNCE) begin
				debounce_q <= cfg_data;
			end else if (cfg_index == kpsh_pkg::CFG_HOLD) begin
				hold_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rows_s1 <= row_levels;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	kpsh_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.rows           (rows_s1),
		.debounce_ticks (debounce_q),
		.hold_ticks     (hold_q),
		.res            (res)
	);

	assign out_valid = valid_s2;
	assign col_drive = res_s2.col_drive;
	assign event_valid = res_s2.event_valid;
	assign key_code = res_s2.key_code;
	assign event_kind = res_s2.event_kind;

endmodule

/* dv/matrix_keypad_scan_hold_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the keypad scan-hold unit: emulated key matrix, scan predictor, checker.
module matrix_keypad_scan_hold_unit_tb;

	localparam int STALL_LIMIT = 1000;
	localparam int MAX_REPORTS = 10;
	localparam int KEYS = kpsh_pkg::ROWS * kpsh_pkg::COLS;

	localparam logic [kpsh_pkg::CODE_W-1:0] KEY_CHARS [kpsh_pkg::ROWS][kpsh_pkg::COLS] = '{
		'{"1", "2", "3", "X", "Y"},
		'{"4", "5", "6", "7", "Z"},
		'{"8", "9", "A", "B", "C"},
		'{"W", "T", "D", "E", "F"}
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [kpsh_pkg::ROWS-1:0]      row_levels = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [kpsh_pkg::COLS-1:0]      col_drive;
	logic                           event_valid;
	logic [kpsh_pkg::CODE_W-1:0]    key_code;
	logic [kpsh_pkg::KIND_W-1:0]    event_kind;
	logic                           cfg_we = 1'b0;
	logic [kpsh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [kpsh_pkg::CNT_W-1:0]     cfg_data = '0;

	// predictor copy of the registers and scan state
	logic [kpsh_pkg::CNT_W-1:0]  cfg_debounce = kpsh_pkg::DEBOUNCE_RST;
	logic [kpsh_pkg::CNT_W-1:0]  cfg_hold = kpsh_pkg::HOLD_RST;
	kpsh_pkg::phase_t            kp_phase = kpsh_pkg::PH_ANY;
	logic [kpsh_pkg::COL_W-1:0]  kp_col = '0;
	logic [kpsh_pkg::CNT_W-1:0]  kp_deb_cnt = '0;
	logic [kpsh_pkg::CNT_W-1:0]  kp_hold_cnt = '0;
	logic [kpsh_pkg::CODE_W-1:0] kp_held_code = '0;
	kpsh_pkg::mode_t             kp_mode = kpsh_pkg::MODE_REL;
	logic [kpsh_pkg::COLS-1:0]   kp_drive = kpsh_pkg::ALL_COLS;

	kpsh_pkg::res_t pending_scan_results[$];
	kpsh_pkg::res_t mon_got;
	kpsh_pkg::res_t mon_want;

	int n_errors = 0;
	int n_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int rcv_run = 0;
	bit rcv_stalling = 1'b0;
	bit snd_idle_en = 1'b0;
	bit rcv_idle_en = 1'b0;

	matrix_keypad_scan_hold_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.row_levels  (row_levels),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.col_drive   (col_drive),
		.event_valid (event_valid),
		.key_code    (key_code),
		.event_kind  (event_kind),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic kpsh_pkg::res_t scan_tick(input logic [kpsh_pkg::ROWS-1:0] rows);
		kpsh_pkg::res_t res;
		logic done;
		logic found;
		logic [kpsh_pkg::CODE_W-1:0] code;
		int low_row;
		res = '0;
		res.col_drive = kpsh_pkg::ALL_COLS;
		done = 1'b0;
		found = 1'b0;
		code = '0;
		low_row = -1;
		for (int r = kpsh_pkg::ROWS - 1; r >= 0; r--) begin
			if (rows[r]) low_row = r;
		end
		case (kp_phase)
			kpsh_pkg::PH_WAIT: begin
				if (kp_deb_cnt != kpsh_pkg::CNT_MAX) kp_deb_cnt = kp_deb_cnt + 1'b1;
				if (kp_deb_cnt >= cfg_debounce) begin
					if (rows != '0) begin
						kp_col = '0;
						res.col_drive = kpsh_pkg::FIRST_COL;
						kp_phase = kpsh_pkg::PH_COL;
					end else begin
						done = 1'b1;
						kp_phase = kpsh_pkg::PH_ANY;
					end
				end
			end
			kpsh_pkg::PH_COL: begin
				if (low_row >= 0) begin
					done = 1'b1;
					found = 1'b1;
					code = KEY_CHARS[low_row][kp_col];
					kp_phase = kpsh_pkg::PH_ANY;
				end else begin
					kp_col = kp_col + 1'b1;
					if (kp_col < kpsh_pkg::COL_W'(kpsh_pkg::COLS - 1)) begin
						res.col_drive = kpsh_pkg::FIRST_COL << kp_col;
					end else begin
						kp_phase = kpsh_pkg::PH_LAST;
					end
				end
			end
			kpsh_pkg::PH_LAST: begin
				// all columns high again: any row left belongs to the last column
				done = 1'b1;
				if (low_row >= 0) begin
					found = 1'b1;
					code = KEY_CHARS[low_row][kpsh_pkg::COLS-1];
				end
				kp_phase = kpsh_pkg::PH_ANY;
			end
			default: begin
				if (rows != '0) begin
					kp_deb_cnt = '0;
					kp_phase = kpsh_pkg::PH_WAIT;
				end else begin
					done = 1'b1;
				end
			end
		endcase
		case (kp_mode)
			kpsh_pkg::MODE_TIME: begin
				if (kp_hold_cnt != kpsh_pkg::CNT_MAX) kp_hold_cnt = kp_hold_cnt + 1'b1;
				// hold timeout wins over a scan ending on the same tick
				if (kp_hold_cnt >= cfg_hold) begin
					res.event_valid = 1'b1;
					res.event_kind = kpsh_pkg::EV_HOLD;
					res.key_code = kp_held_code;
					kp_mode = kpsh_pkg::MODE_HELD;
				end else if (done && !found) begin
					res.event_valid = 1'b1;
					res.event_kind = kpsh_pkg::EV_PRESS;
					res.key_code = kp_held_code;
					kp_mode = kpsh_pkg::MODE_REL;
				end
			end
			kpsh_pkg::MODE_HELD: begin
				if (done) begin
					res.event_valid = 1'b1;
					if (found) begin
						res.event_kind = kpsh_pkg::EV_HOLD;
						kp_held_code = code;
						res.key_code = code;
					end else begin
						res.event_kind = kpsh_pkg::EV_RELEASE;
						res.key_code = kp_held_code;
						kp_mode = kpsh_pkg::MODE_REL;
					end
				end
			end
			default: begin
				kp_mode = kpsh_pkg::MODE_REL;
				if (done && found) begin
					kp_held_code = code;
					kp_hold_cnt = '0;
					kp_mode = kpsh_pkg::MODE_TIME;
				end
			end
		endcase
		kp_drive = res.col_drive;
		return res;
	endfunction

	// row levels the matrix gives back for the columns currently driven
	function automatic logic [kpsh_pkg::ROWS-1:0] pad_rows(input logic [KEYS-1:0] keys);
		logic [kpsh_pkg::ROWS-1:0] rows;
		rows = '0;
		for (int r = 0; r < kpsh_pkg::ROWS; r++) begin
			for (int c = 0; c < kpsh_pkg::COLS; c++) begin
				if (keys[r*kpsh_pkg::COLS+c] && kp_drive[c]) rows[r] = 1'b1;
			end
		end
		return rows;
	endfunction

	function automatic logic [KEYS-1:0] key_at(input int r, input int c);
		return KEYS'(1) << (r * kpsh_pkg::COLS + c);
	endfunction

	task automatic note_error(input string msg);
		n_errors++;
		if (n_errors <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
	endtask

	task automatic send_tick(input logic [kpsh_pkg::ROWS-1:0] rows);
		int gap;
		if (snd_idle_en && burst_left == 0) begin
			gap = $urandom_range(0, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		row_levels <= rows;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_scan_results.push_back(scan_tick(rows));
		n_sent++;
	endtask

	task automatic press_for(input logic [KEYS-1:0] keys, input int n_ticks);
		repeat (n_ticks) send_tick(pad_rows(keys));
	endtask

	task automatic noise_for(input int n_ticks);
		repeat (n_ticks) send_tick(kpsh_pkg::ROWS'($urandom));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_scan_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_config(input logic [kpsh_pkg::CNT_W-1:0] deb,
		input logic [kpsh_pkg::CNT_W-1:0] hold);
		cfg_we <= 1'b1;
		cfg_index <= kpsh_pkg::CFG_DEBOUNCE;
		cfg_data <= deb;
		@(posedge clk);
		cfg_debounce = deb;
		cfg_index <= kpsh_pkg::CFG_HOLD;
		cfg_data <= hold;
		@(posedge clk);
		cfg_hold = hold;
		cfg_we <= 1'b0;
	endtask

	task automatic test_default_regs();
		snd_idle_en = 1'b0;
		rcv_idle_en = 1'b1;
		// short press past the reset debounce time but under the reset hold time
		press_for(key_at(0, 1), 30);
		press_for('0, 25);
		drain_results();
	endtask

	task automatic test_directed_events();
		snd_idle_en = 1'b0;
		rcv_idle_en = 1'b0;
		set_config(16'd1, 16'd6);
		send_tick('1);
		send_tick('0);
		press_for(key_at(0, 0), 4);
		press_for('0, 3);
		// last column, held past timeout, then released
		press_for(key_at(3, 4), 12);
		press_for('0, 4);
		// several keys down, lowest row wins
		press_for(key_at(1, 2) | key_at(3, 2) | key_at(2, 3), 8);
		press_for('0, 3);
		drain_results();
	endtask

	task automatic test_zero_regs();
		snd_idle_en = 1'b1;
		rcv_idle_en = 1'b1;
		set_config(16'd0, 16'd0);
		press_for(key_at(2, 0), 6);
		press_for('0, 3);
		drain_results();
	endtask

	task automatic test_random_scans(input int n_items, input int deb_lo, input int deb_hi,
		input int hold_lo, input int hold_hi, input bit idle_en);
		int deb;
		int hold;
		int start;
		int kind;
		int dur;
		logic [KEYS-1:0] keys;
		snd_idle_en = idle_en;
		rcv_idle_en = idle_en;
		deb = $urandom_range(deb_lo, deb_hi);
		hold = $urandom_range(hold_lo, hold_hi);
		set_config(kpsh_pkg::CNT_W'(deb), kpsh_pkg::CNT_W'(hold));
		start = n_sent;
		while (n_sent - start < n_items) begin
			kind = $urandom_range(0, 9);
			dur = $urandom_range(1, 2 * hold + 3 * (deb + 8));
			if (dur > n_items - (n_sent - start)) dur = n_items - (n_sent - start);
			keys = key_at($urandom_range(0, kpsh_pkg::ROWS - 1),
				$urandom_range(0, kpsh_pkg::COLS - 1));
			if (kind == 6 || kind == 7) keys = KEYS'($urandom);
			if (kind == 8) begin
				noise_for($urandom_range(1, 6));
			end else if (kind == 9) begin
				// contact bounce
				repeat ($urandom_range(2, 10)) begin
					press_for(keys, 1);
					press_for('0, 1);
				end
			end else begin
				press_for(keys, dur);
			end
			press_for('0, $urandom_range(1, deb + 8));
		end
		drain_results();
	endtask

	task automatic test_max_regs();
		snd_idle_en = 1'b1;
		rcv_idle_en = 1'b1;
		// longest debounce: a short press never confirms
		set_config(kpsh_pkg::CNT_MAX, kpsh_pkg::CNT_MAX);
		press_for(key_at(2, 2), 30);
		press_for('0, 10);
		drain_results();
		// longest hold: a key let go early reports as a press
		set_config(16'd2, kpsh_pkg::CNT_MAX);
		press_for(key_at(2, 2), 30);
		press_for('0, 15);
		drain_results();
	endtask

	always @(posedge clk) begin
		if (rcv_run == 0) begin
			rcv_stalling = !rcv_stalling;
			rcv_run = rcv_stalling ? $urandom_range(1, 6) : $urandom_range(1, 20);
		end
		rcv_run--;
		out_stall <= rcv_idle_en && rcv_stalling;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			mon_got = {col_drive, event_valid, key_code, event_kind};
			if (pending_scan_results.size() == 0) begin
				note_error($sformatf("unexpected beat: col=%h ev=%b code=%h kind=%0d",
					col_drive, event_valid, key_code, event_kind));
			end else begin
				mon_want = pending_scan_results.pop_front();
				if (mon_got.col_drive !== mon_want.col_drive
					|| mon_got.event_valid !== mon_want.event_valid
					|| mon_got.key_code !== mon_want.key_code
					|| mon_got.event_kind !== mon_want.event_kind) begin
					note_error($sformatf({"exp col=%h ev=%b code=%h kind=%0d, ",
						"got col=%h ev=%b code=%h kind=%0d"},
						mon_want.col_drive, mon_want.event_valid, mon_want.key_code,
						mon_want.event_kind, mon_got.col_drive, mon_got.event_valid,
						mon_got.key_code, mon_got.event_kind));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** matrix_keypad_scan_hold_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_regs();
		test_directed_events();
		test_zero_regs();
		test_random_scans(175, 1, 4, 2, 30, 1'b1);
		test_random_scans(175, 5, 30, 20, 120, 1'b1);
		test_random_scans(175, 1, 1, 1, 1, 1'b0);
		test_random_scans(175, 1, 3, 1, 12, 1'b1);
		test_max_regs();
		repeat (10) @(posedge clk);
		if (pending_scan_results.size() != 0) begin
			note_error($sformatf("%0d result beats never arrived",
				pending_scan_results.size()));
		end
		if (n_errors == 0) begin
			$display("** matrix_keypad_scan_hold_unit: PASSED **");
		end else begin
			$display("** matrix_keypad_scan_hold_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
sv/kpsh_pkg.sv
sv/kpsh_core.sv
sv/matrix_keypad_scan_hold_unit.sv
dv/matrix_keypad_scan_hold_unit_tb.sv
